[rtl/positional_list_insert_delete_search_defines.svh]
// assertion macros shared by the checker
`ifndef POSITIONAL_LIST_INSERT_DELETE_SEARCH_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_SEARCH_DEFINES_SVH

// property checked only while out of reset
`define PLL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked at every edge, reset included
`define PLL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/pll_pkg.sv]
package pll_pkg;

    localparam int DATA_W  = 32;
    localparam int FIELD_W = 5;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LOCATE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic              ins_en;
        logic              del_en;
        logic              find_en;
        logic [DATA_W-1:0] val;
    } pll_op_t;

endpackage

[rtl/pll_cell.sv]
module pll_cell import pll_pkg::*; #(
    parameter int INDEX = 0,
    parameter int CW    = 5,
    parameter int PW    = 6
) (
    input  logic              aclk,
    input  pll_op_t           op,
    input  logic [PW-1:0]     pos0,
    input  logic [CW-1:0]     count,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] entry,
    output logic              match,
    output logic [DATA_W-1:0] sel_data
);

    localparam logic [PW-1:0] IDX_P = PW'(INDEX);
    localparam logic [CW-1:0] IDX_C = CW'(INDEX);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (op.ins_en) begin
            if (IDX_P == pos0) begin
                entry_next = op.val;
            end else if (IDX_P > pos0) begin
                entry_next = left_data;
            end
        end else if (op.del_en) begin
            if (IDX_P >= pos0) begin
                entry_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry    = entry_reg;
    assign match    = op.find_en && (entry_reg == op.val) && (IDX_C < count);
    assign sel_data = (op.del_en && (IDX_P == pos0)) ? entry_reg : '0;

endmodule

[rtl/positional_list_insert_delete_search.sv]
// Positional list of up to CAPACITY signed 32-bit entries held in a row of
// cells, one entry per cell. Every command is done in the cycle of its input
// transfer: an insert moves each cell at or above the position one place up
// and writes the new value, a delete moves the cells above the position one
// place down, and a locate has every cell compare its entry with the key at
// once. The result then passes through a stage that holds the cell flags
// and the removed value, then the output register that turns the first
// matching cell into its position. With the output drained, one command is
// taken every cycle; a stalled output holds both stages and then drops
// s_ready. Entries start undefined and are never read before written, so
// there is no clearing pass after reset; only length and valid flags reset.
// Status 1 flags a bad position (checked first), status 2 an insert into a
// full list; either way the list is left alone. Command code 3 does nothing.
module positional_list_insert_delete_search import pll_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_cmd,
    input  logic [FIELD_W-1:0]        s_position,
    input  logic signed [DATA_W-1:0]  s_item_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic signed [DATA_W-1:0]  m_removed_value,
    output logic [FIELD_W-1:0]        m_found_position,
    output logic [FIELD_W-1:0]        m_list_length
);

    // width of the length counter, and of position compares (holds length + 1)
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW + 1 > FIELD_W + 1) ? CW + 1 : FIELD_W + 1;

    // list length
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // stage 1: command done in the cells, flags held for encoding
    logic                p1_valid_reg;
    logic                p1_valid_next;
    logic [1:0]          p1_status_reg;
    logic [DATA_W-1:0]   p1_removed_reg;
    logic [CAPACITY-1:0] p1_match_reg;
    logic [CW-1:0]       p1_len_reg;

    // output register
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [1:0]          m_status_reg;
    logic [DATA_W-1:0]   m_removed_reg;
    logic [FIELD_W-1:0]  m_found_reg;
    logic [FIELD_W-1:0]  m_len_reg;

    logic accept;
    logic p1_adv;

    // command decode
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic [PW-1:0] pos0;
    logic          pos_nz;
    logic          ins_pos_ok;
    logic          del_pos_ok;
    logic          is_full;
    logic [1:0]    status_now;
    pll_op_t       op;

    // cell row
    logic [DATA_W-1:0]   entry_w [CAPACITY];
    logic [DATA_W-1:0]   sel_w   [CAPACITY];
    logic [CAPACITY-1:0] match_w;
    logic [DATA_W-1:0]   removed_now;

    // first-match encode
    logic [CAPACITY-1:0] first_hit;
    logic [CW-1:0]       found_idx;

    // handshake: stage 1 moves on when the output slot is free
    assign p1_adv  = !m_valid_reg || m_ready;
    assign s_ready = !p1_valid_reg || p1_adv;
    assign accept  = s_valid && s_ready;

    // position checks, all in PW bits so length + 1 never wraps
    assign pos_ext    = PW'(s_position);
    assign cnt_ext    = PW'(count_reg);
    assign pos0       = pos_ext - PW'(1);
    assign pos_nz     = (s_position != '0);
    assign ins_pos_ok = pos_nz && (pos_ext <= cnt_ext + PW'(1));
    assign del_pos_ok = pos_nz && (pos_ext <= cnt_ext);
    assign is_full    = (count_reg == CW'(CAPACITY));

    always_comb begin
        op         = '0;
        op.val     = s_item_value;
        status_now = ST_OK;
        count_next = count_reg;
        case (s_cmd)
            CMD_INSERT: begin
                if (!ins_pos_ok) begin
                    status_now = ST_RANGE;
                end else if (is_full) begin
                    status_now = ST_FULL;
                end else begin
                    op.ins_en  = accept;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_DELETE: begin
                if (!del_pos_ok) begin
                    status_now = ST_RANGE;
                end else begin
                    op.del_en  = accept;
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_LOCATE: begin
                op.find_en = accept;
            end
            default: begin
                status_now = ST_OK;
            end
        endcase
    end

    // row of cells, each handing its entry to both neighbors
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = entry_w[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = entry_w[i+1];
        end

        pll_cell #(
            .INDEX (i),
            .CW    (CW),
            .PW    (PW)
        ) u_cell (
            .aclk       (aclk),
            .op         (op),
            .pos0       (pos0),
            .count      (count_reg),
            .left_data  (left_w),
            .right_data (right_w),
            .entry      (entry_w[i]),
            .match      (match_w[i]),
            .sel_data   (sel_w[i])
        );
    end

    // only the delete target drives its entry, the rest give zero
    always_comb begin
        removed_now = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            removed_now = removed_now | sel_w[i];
        end
    end

    // lowest set flag, then its 1-based position
    assign first_hit = p1_match_reg & (~p1_match_reg + CAPACITY'(1));

    always_comb begin
        found_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_hit[i]) begin
                found_idx = found_idx | CW'(i + 1);
            end
        end
    end

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (accept) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (p1_valid_reg && p1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload of both stages
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_status_reg  <= status_now;
            p1_removed_reg <= removed_now;
            p1_match_reg   <= match_w;
            p1_len_reg     <= count_next;
        end
        if (p1_valid_reg && p1_adv) begin
            m_status_reg  <= p1_status_reg;
            m_removed_reg <= p1_removed_reg;
            m_found_reg   <= FIELD_W'(found_idx);
            m_len_reg     <= FIELD_W'(p1_len_reg);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_removed_value  = m_removed_reg;
    assign m_found_position = m_found_reg;
    assign m_list_length    = m_len_reg;

endmodule

[rtl/pll_checker.sv]
`include "positional_list_insert_delete_search_defines.svh"

module pll_checker import pll_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [1:0]                m_status,
    input logic signed [DATA_W-1:0]  m_removed_value,
    input logic [FIELD_W-1:0]        m_found_position,
    input logic [FIELD_W-1:0]        m_list_length
);

    // no result right after reset
    `PLL_ASSERT_ALWAYS(a_idle_after_reset, !aresetn |=> !m_valid, "result valid after reset")

    // a stalled result holds
    `PLL_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_removed_value) && $stable(m_found_position) && $stable(m_list_length), "stalled result changed")

    // a rejected command reports nothing else
    `PLL_ASSERT(a_reject_clean, m_valid && m_status != ST_OK |-> m_removed_value == 0 && m_found_position == 0, "rejected command carries data")

    // full is only reported at capacity
    `PLL_ASSERT(a_full_len, m_valid && m_status == ST_FULL |-> m_list_length == FIELD_W'(CAPACITY), "full status below capacity")

endmodule

bind positional_list_insert_delete_search pll_checker #(.CAPACITY(CAPACITY)) u_pll_checker (.*);

[sim/tb.sv]
module tb import pll_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CAPACITY   = 16;
    localparam int         RAND_ITEMS = 1850;
    // spare command code, the block treats it as a no-op
    localparam logic [1:0] CMD_NOP    = 2'd3;

    // one result transfer as the block reports it
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] removed;
        logic [FIELD_W-1:0]       found;
        logic [FIELD_W-1:0]       len;
    } list_result_t;

    // directed stimulus row: the command is sent rep times; where typed is set
    // the expected result is the one written in the row, else the predictor's
    typedef struct packed {
        logic [1:0]         cmd;
        logic [FIELD_W-1:0] pos;
        logic [DATA_W-1:0]  val;
        int                 rep;
        bit                 typed;
        logic [1:0]         e_status;
        logic [DATA_W-1:0]  e_removed;
        logic [FIELD_W-1:0] e_found;
        logic [FIELD_W-1:0] e_len;
    } dir_row_t;

    localparam int DIR_ROWS = 25;

    // walk from an empty list through every error, up to full and back down
    dir_row_t dir_rows [DIR_ROWS] = '{
        // empty list: delete is out of range, locate finds nothing
        '{CMD_DELETE, 5'd1,  32'h0000_0000, 1,  1'b1, ST_RANGE, 32'h0, 5'd0,  5'd0},
        '{CMD_LOCATE, 5'd0,  32'h0000_0000, 1,  1'b1, ST_OK,    32'h0, 5'd0,  5'd0},
        // insert at position zero and one past the end
        '{CMD_INSERT, 5'd0,  32'h1111_1111, 1,  1'b1, ST_RANGE, 32'h0, 5'd0,  5'd0},
        '{CMD_INSERT, 5'd2,  32'h2222_2222, 1,  1'b1, ST_RANGE, 32'h0, 5'd0,  5'd0},
        // the two extreme values
        '{CMD_INSERT, 5'd1,  32'h8000_0000, 1,  1'b1, ST_OK,    32'h0, 5'd0,  5'd1},
        '{CMD_INSERT, 5'd2,  32'h7fff_ffff, 1,  1'b1, ST_OK,    32'h0, 5'd0,  5'd2},
        // spare code with every other input bit set does nothing
        '{CMD_NOP,    5'd31, 32'hffff_ffff, 1,  1'b1, ST_OK,    32'h0, 5'd0,  5'd2},
        '{CMD_LOCATE, 5'd0,  32'h7fff_ffff, 1,  1'b1, ST_OK,    32'h0, 5'd2,  5'd2},
        '{CMD_LOCATE, 5'd0,  32'h1234_5678, 1,  1'b1, ST_OK,    32'h0, 5'd0,  5'd2},
        '{CMD_INSERT, 5'd31, 32'h3333_3333, 1,  1'b1, ST_RANGE, 32'h0, 5'd0,  5'd2},
        '{CMD_DELETE, 5'd3,  32'h0000_0000, 1,  1'b1, ST_RANGE, 32'h0, 5'd0,  5'd2},
        '{CMD_DELETE, 5'd1,  32'h0000_0000, 1,  1'b1, ST_OK, 32'h8000_0000, 5'd0, 5'd1},
        // fill to capacity with duplicates in front
        '{CMD_INSERT, 5'd1,  32'h5a5a_5a5a, 15, 1'b0, ST_OK,    32'h0, 5'd0,  5'd0},
        // first match wins, and the last cell is searched too
        '{CMD_LOCATE, 5'd0,  32'h5a5a_5a5a, 1,  1'b1, ST_OK,    32'h0, 5'd1,  5'd16},
        '{CMD_LOCATE, 5'd0,  32'h7fff_ffff, 1,  1'b1, ST_OK,    32'h0, 5'd16, 5'd16},
        // full list: good positions report full, bad ones report range first
        '{CMD_INSERT, 5'd1,  32'h4444_4444, 1,  1'b1, ST_FULL,  32'h0, 5'd0,  5'd16},
        '{CMD_INSERT, 5'd17, 32'h4444_4444, 1,  1'b1, ST_FULL,  32'h0, 5'd0,  5'd16},
        '{CMD_INSERT, 5'd18, 32'h4444_4444, 1,  1'b1, ST_RANGE, 32'h0, 5'd0,  5'd16},
        '{CMD_INSERT, 5'd0,  32'h4444_4444, 1,  1'b1, ST_RANGE, 32'h0, 5'd0,  5'd16},
        '{CMD_DELETE, 5'd17, 32'h0000_0000, 1,  1'b1, ST_RANGE, 32'h0, 5'd0,  5'd16},
        '{CMD_DELETE, 5'd16, 32'h0000_0000, 1,  1'b1, ST_OK, 32'h7fff_ffff, 5'd0, 5'd15},
        // drain to empty from the front
        '{CMD_DELETE, 5'd1,  32'h0000_0000, 15, 1'b0, ST_OK,    32'h0, 5'd0,  5'd0},
        '{CMD_DELETE, 5'd1,  32'h0000_0000, 1,  1'b1, ST_RANGE, 32'h0, 5'd0,  5'd0},
        '{CMD_INSERT, 5'd1,  32'h0000_0000, 1,  1'b1, ST_OK,    32'h0, 5'd0,  5'd1},
        '{CMD_LOCATE, 5'd0,  32'h0000_0000, 1,  1'b1, ST_OK,    32'h0, 5'd1,  5'd1}
    };

    logic                     aclk             = 1'b0;
    logic                     aresetn          = 1'b0;
    logic                     s_valid          = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_cmd            = CMD_NOP;
    logic [FIELD_W-1:0]       s_position       = '0;
    logic signed [DATA_W-1:0] s_item_value     = '0;
    logic                     m_valid;
    logic                     m_ready          = 1'b0;
    logic [1:0]               m_status;
    logic signed [DATA_W-1:0] m_removed_value;
    logic [FIELD_W-1:0]       m_found_position;
    logic [FIELD_W-1:0]       m_list_length;

    // predictor state: shadow copy of the list
    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int                       list_count = 0;

    // results still owed by the block, oldest first
    list_result_t             pending_results [$];
    int                       err_count = 0;
    // when set neither side idles
    bit                       quiet = 1'b0;

    positional_list_insert_delete_search #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_position       (s_position),
        .s_item_value     (s_item_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_removed_value  (m_removed_value),
        .m_found_position (m_found_position),
        .m_list_length    (m_list_length)
    );

    always #5 aclk = ~aclk;

    // apply one command to the shadow list and return what the block must report
    function automatic list_result_t apply_list_cmd(input logic [1:0] cmd,
                                                    input logic [FIELD_W-1:0] pos,
                                                    input logic signed [DATA_W-1:0] val);
        list_result_t res;
        int           p;
        int           k;
        res = '0;
        p   = int'(pos);
        case (cmd)
            CMD_INSERT: begin
                if (p < 1 || p > list_count + 1) begin
                    res.status = ST_RANGE;
                end else if (list_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    // open a hole at the position, later entries move up
                    for (k = list_count; k >= p; k--) begin
                        list_mem[k] = list_mem[k-1];
                    end
                    list_mem[p-1] = val;
                    list_count++;
                end
            end
            CMD_DELETE: begin
                if (p < 1 || p > list_count) begin
                    res.status = ST_RANGE;
                end else begin
                    res.removed = list_mem[p-1];
                    // close the gap, later entries move down
                    for (k = p; k < list_count; k++) begin
                        list_mem[k-1] = list_mem[k];
                    end
                    list_count--;
                end
            end
            CMD_LOCATE: begin
                // first match from the front
                for (k = 0; k < list_count; k++) begin
                    if (res.found == '0 && list_mem[k] == val) begin
                        res.found = FIELD_W'(k + 1);
                    end
                end
            end
            default: begin
                // spare code: nothing changes
            end
        endcase
        res.len = FIELD_W'(list_count);
        return res;
    endfunction

    // print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    // one input transfer, with an occasional idle gap in front of it;
    // the expectation is recorded at the edge that takes the transfer
    task automatic send_cmd(input logic [1:0] cmd, input logic [FIELD_W-1:0] pos,
                            input logic [DATA_W-1:0] val, input bit typed,
                            input list_result_t typed_res);
        list_result_t res;
        if (!quiet && $urandom_range(99) < 4) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_position   <= pos;
        s_item_value <= val;
        do @(posedge aclk); while (!s_ready);
        res = apply_list_cmd(cmd, pos, val);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // receiver backpressure: drop m_ready with a chance of about 7 in 100 unless quiet
    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(99) >= 7);
    end

    // result checker: every result transfer against the oldest expectation
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, status %0d len %0d",
                                          m_status, m_list_length));
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_status, want.status));
                end
                if (m_removed_value !== want.removed) begin
                    report_mismatch($sformatf("removed_value got %h want %h",
                                              m_removed_value, want.removed));
                end
                if (m_found_position !== want.found) begin
                    report_mismatch($sformatf("found_position got %0d want %0d",
                                              m_found_position, want.found));
                end
                if (m_list_length !== want.len) begin
                    report_mismatch($sformatf("list_length got %0d want %0d",
                                              m_list_length, want.len));
                end
            end
        end
    end

    // stimulus: reset, directed table, then random traffic
    initial begin
        list_result_t no_res;
        list_result_t row_res;
        dir_row_t     row;
        logic [1:0]         cmd;
        logic [FIELD_W-1:0] pos;
        logic [DATA_W-1:0]  val;
        bit           filling;
        int           pick;
        no_res  = '0;
        filling = 1'b1;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        for (int r = 0; r < DIR_ROWS; r++) begin
            row     = dir_rows[r];
            row_res = '{row.e_status, row.e_removed, row.e_found, row.e_len};
            for (int n = 0; n < row.rep; n++) begin
                send_cmd(row.cmd, row.pos, row.val, row.typed, row_res);
            end
        end

        // random part: mostly well-formed commands, the list swinging between
        // empty and full so both ends get exercised
        for (int i = 0; i < RAND_ITEMS; i++) begin
            // a long stretch with no idling on either side
            quiet = (i >= 900 && i < 1200);

            if (list_count == CAPACITY) begin
                filling = 1'b0;
            end else if (list_count == 0) begin
                filling = 1'b1;
            end else if ($urandom_range(99) < 3) begin
                filling = !filling;
            end

            // value: small pool for duplicates, current entries for hits,
            // extremes, or any 32-bit pattern
            pick = $urandom_range(9);
            if (pick < 4) begin
                val = DATA_W'($signed($urandom_range(7)) - 4);
            end else if (pick < 6 && list_count > 0) begin
                val = list_mem[$urandom_range(list_count - 1)];
            end else if (pick == 6) begin
                case ($urandom_range(3))
                    0:       val = 32'h8000_0000;
                    1:       val = 32'h7fff_ffff;
                    2:       val = 32'hffff_ffff;
                    default: val = 32'h0000_0000;
                endcase
            end else begin
                val = $urandom;
            end

            pick = $urandom_range(99);
            if (pick < 5) begin
                // noise: any code, any position
                cmd = 2'($urandom_range(3));
                pos = FIELD_W'($urandom_range(31));
            end else begin
                if (pick < 30) begin
                    cmd = CMD_LOCATE;
                end else if (pick < 80) begin
                    cmd = filling ? CMD_INSERT : CMD_DELETE;
                end else begin
                    cmd = filling ? CMD_DELETE : CMD_INSERT;
                end
                pos = FIELD_W'($urandom_range(31));
                if (cmd == CMD_INSERT) begin
                    pos = FIELD_W'($urandom_range(list_count + 1, 1));
                end else if (cmd == CMD_DELETE && list_count > 0) begin
                    pos = FIELD_W'($urandom_range(list_count, 1));
                end
            end
            send_cmd(cmd, pos, val, 1'b0, no_res);
        end
        s_valid <= 1'b0;
        quiet = 1'b0;

        // drain, then wait on to catch stray results
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("positional_list_insert_delete_search verification clean");
        end else begin
            $display("positional_list_insert_delete_search verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("positional_list_insert_delete_search verification failed");
        $finish;
    end

endmodule
